// File: sv/ufl_pkg.sv
package ufl_pkg;

  localparam int DEF_CORDIC_STEPS = 16;
  localparam int ATAN_LEN = 24;
  localparam int IT_W = 5;
  localparam int AW = 34;
  localparam int MW = 36;
  localparam logic signed [AW-1:0] CORDIC_INIT = 34'sd652032874;

  localparam logic [2:0] REG_OFFSET_DISTANCE = 3'd0;
  localparam logic [2:0] REG_OFFSET_RECIPROCAL = 3'd1;
  localparam logic [2:0] REG_POSITION_GAIN = 3'd2;
  localparam logic [2:0] REG_TEST_MODE = 3'd3;
  localparam logic [2:0] REG_TEST_VEL_X = 3'd4;
  localparam logic [2:0] REG_TEST_VEL_Y = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_CLOAD, S_CORD, S_MLOAD, S_MUL, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_OX, OP_OY, OP_RX, OP_RY, OP_GX, OP_GY, OP_V1, OP_V2, OP_W1, OP_W2, OP_WR
  } op_t;

  function automatic logic [31:0] atan_entry(input logic [IT_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd536870912;
      5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;
      5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;
      5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;
      5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;
      5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [55:0] v);
    logic [31:0] r;
    if (v > 56'sd2147483647) begin
      r = 32'h7fffffff;
    end else if (v < -56'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: sv/unicycle_feedback_linearization.sv
// Offset-point feedback-linearizing velocity controller for a differential-drive robot.
// Input transactions arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser is the kind:
// 0 is a control tick that updates the stored point velocity and gives no result,
// 1 is a command that returns one transaction on m_tvalid/m_tready/m_tdata.
// s_tready is high only while the block is idle; one item is processed at a time.
// Every item runs a CORDIC of min(CORDIC_STEPS, 24) iterations, one per cycle, and a
// sequence of products on a radix-2 shift-add multiplier, each with its load.
// A command runs one CORDIC and seven products before its result is presented, a tick
// runs two CORDICs and six products, or one CORDIC and two products when test mode
// is set. The next transaction is accepted once the block is idle again. The
// multiplier sets the throughput.
// The result sits in an output register; if the receiver stalls, the block finishes
// the next command and then waits until that register is taken.
// Configuration registers must be written through the APB port only while idle; the
// block does not enforce this. Synchronous reset clears the stored point velocity,
// loads the register defaults and empties the output register.
module unicycle_feedback_linearization #(
  parameter int CORDIC_STEPS = ufl_pkg::DEF_CORDIC_STEPS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, heading, ref_x, ref_y, ref_heading
  input  logic [159:0] s_tdata,
  // kind
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // linear_speed, turn_rate, point_x, point_y
  output logic [127:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int NSTEP = (CORDIC_STEPS > ufl_pkg::ATAN_LEN) ? ufl_pkg::ATAN_LEN : CORDIC_STEPS;
  localparam int MW = ufl_pkg::MW;
  localparam int AW = ufl_pkg::AW;
  localparam int IT_W = ufl_pkg::IT_W;
  localparam int MCW = $clog2(MW + 1);

  ufl_pkg::state_t state, state_next;
  ufl_pkg::op_t op;

  logic [20:0] offset_distance;
  logic [26:0] offset_reciprocal;
  logic [24:0] position_gain;
  logic        test_mode;
  logic [31:0] test_vel_x, test_vel_y;

  logic               kind;
  logic signed [31:0] pos_x, pos_y, ref_x, ref_y;
  logic signed [15:0] heading, ref_heading;

  logic                 cref, flip;
  logic [IT_W-1:0]      it;
  logic signed [AW-1:0] cx, cy, cz, cs_c, cs_s;
  logic signed [AW-1:0] ox, oy, rx, ry;
  logic signed [31:0]   pv_x, pv_y, wn;
  logic [31:0]          lin, trate;
  logic signed [2*MW-1:0] tacc;

  logic signed [MW-1:0] ma, mb_unused_sign;
  logic [MW-1:0]        mb, lo;
  logic signed [MW:0]   hi;
  logic [MCW-1:0]       mcnt;

  logic cfg_wr, mul_done, cord_done, out_load;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_distance <= 21'd6554;
      offset_reciprocal <= 27'd655360;
      position_gain <= 25'd65536;
      test_mode <= 1'b0;
      test_vel_x <= '0;
      test_vel_y <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        ufl_pkg::REG_OFFSET_DISTANCE: offset_distance <= pwdata[20:0];
        ufl_pkg::REG_OFFSET_RECIPROCAL: offset_reciprocal <= pwdata[26:0];
        ufl_pkg::REG_POSITION_GAIN: position_gain <= pwdata[24:0];
        ufl_pkg::REG_TEST_MODE: test_mode <= pwdata[0];
        ufl_pkg::REG_TEST_VEL_X: test_vel_x <= pwdata;
        ufl_pkg::REG_TEST_VEL_Y: test_vel_y <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      ufl_pkg::REG_OFFSET_DISTANCE: prdata = 32'(offset_distance);
      ufl_pkg::REG_OFFSET_RECIPROCAL: prdata = 32'(offset_reciprocal);
      ufl_pkg::REG_POSITION_GAIN: prdata = 32'(position_gain);
      ufl_pkg::REG_TEST_MODE: prdata = 32'(test_mode);
      ufl_pkg::REG_TEST_VEL_X: prdata = test_vel_x;
      ufl_pkg::REG_TEST_VEL_Y: prdata = test_vel_y;
      default: prdata = '0;
    endcase
  end

  // CORDIC datapath.
  logic signed [15:0]   ang;
  logic signed [AW-1:0] z0, xs, ys, at;
  assign ang = cref ? ref_heading : heading;
  assign z0 = AW'(ang) <<< 16;
  assign xs = cx >>> it;
  assign ys = cy >>> it;
  assign at = AW'(signed'(ufl_pkg::atan_entry(it)));
  assign cord_done = (state == ufl_pkg::S_CORD) && (it == IT_W'(NSTEP));

  // Multiplier operands and result formatting.
  logic signed [MW-1:0]   opa, opb, pp;
  logic signed [MW:0]     hi_sum;
  logic signed [2*MW-1:0] prod, vsum, wdif, r30, r16, rv, rw;
  logic signed [AW-1:0]   base, pt_new;

  always_comb begin
    opa = MW'(cs_c);
    opb = MW'(signed'({1'b0, offset_distance}));
    case (op)
      ufl_pkg::OP_OX, ufl_pkg::OP_RX: opa = MW'(cs_c);
      ufl_pkg::OP_OY, ufl_pkg::OP_RY: opa = MW'(cs_s);
      ufl_pkg::OP_GX: begin
        opa = MW'(rx) - MW'(ox);
        opb = MW'(signed'({1'b0, position_gain}));
      end
      ufl_pkg::OP_GY: begin
        opa = MW'(ry) - MW'(oy);
        opb = MW'(signed'({1'b0, position_gain}));
      end
      ufl_pkg::OP_V1: begin opa = MW'(pv_x); opb = MW'(cs_c); end
      ufl_pkg::OP_V2: begin opa = MW'(pv_y); opb = MW'(cs_s); end
      ufl_pkg::OP_W1: begin opa = MW'(pv_y); opb = MW'(cs_c); end
      ufl_pkg::OP_W2: begin opa = MW'(pv_x); opb = MW'(cs_s); end
      ufl_pkg::OP_WR: begin
        opa = MW'(wn);
        opb = MW'(signed'({1'b0, offset_reciprocal}));
      end
      default: ;
    endcase
  end

  assign mb_unused_sign = '0;
  assign pp = mb[0] ? ((mcnt == MCW'(MW - 1)) ? -ma : ma) : mb_unused_sign;
  assign hi_sum = hi + (MW + 1)'(pp);
  assign prod = signed'({hi[MW-1:0], lo});
  assign vsum = tacc + prod;
  assign wdif = tacc - prod;
  assign r30 = (prod + (2*MW)'(64'sd536870912)) >>> 30;
  assign r16 = (prod + (2*MW)'(64'sd32768)) >>> 16;
  assign rv = (vsum + (2*MW)'(64'sd536870912)) >>> 30;
  assign rw = (wdif + (2*MW)'(64'sd536870912)) >>> 30;
  assign base = (op == ufl_pkg::OP_OX) ? AW'(pos_x) : (op == ufl_pkg::OP_OY) ? AW'(pos_y) :
                (op == ufl_pkg::OP_RX) ? AW'(ref_x) : AW'(ref_y);
  assign pt_new = base + r30[AW-1:0];
  assign mul_done = (state == ufl_pkg::S_MUL) && (mcnt == MCW'(MW));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ufl_pkg::S_IDLE: if (s_tvalid) state_next = ufl_pkg::S_CLOAD;
      ufl_pkg::S_CLOAD: state_next = ufl_pkg::S_CORD;
      ufl_pkg::S_CORD: if (cord_done) state_next = ufl_pkg::S_MLOAD;
      ufl_pkg::S_MLOAD: state_next = ufl_pkg::S_MUL;
      ufl_pkg::S_MUL: begin
        if (mul_done) begin
          case (op)
            ufl_pkg::OP_OY: begin
              if (kind) state_next = ufl_pkg::S_MLOAD;
              else if (test_mode) state_next = ufl_pkg::S_IDLE;
              else state_next = ufl_pkg::S_CLOAD;
            end
            ufl_pkg::OP_GY: state_next = ufl_pkg::S_IDLE;
            ufl_pkg::OP_WR: state_next = ufl_pkg::S_OUT;
            default: state_next = ufl_pkg::S_MLOAD;
          endcase
        end
      end
      ufl_pkg::S_OUT: if (!m_tvalid || m_tready) state_next = ufl_pkg::S_IDLE;
      default: state_next = ufl_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    case (state)
      ufl_pkg::S_IDLE: s_tready = 1'b1;
      ufl_pkg::S_OUT: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ufl_pkg::S_IDLE;
      op <= ufl_pkg::OP_OX;
      cref <= 1'b0;
      pv_x <= '0;
      pv_y <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (state == ufl_pkg::S_IDLE) cref <= 1'b0;
      if (cord_done) op <= cref ? ufl_pkg::OP_RX : ufl_pkg::OP_OX;
      if (mul_done) begin
        case (op)
          ufl_pkg::OP_OX: op <= ufl_pkg::OP_OY;
          ufl_pkg::OP_OY: begin
            op <= ufl_pkg::OP_V1;
            if (!kind && test_mode) begin
              pv_x <= test_vel_x;
              pv_y <= test_vel_y;
            end
            if (!kind) cref <= 1'b1;
          end
          ufl_pkg::OP_RX: op <= ufl_pkg::OP_RY;
          ufl_pkg::OP_RY: op <= ufl_pkg::OP_GX;
          ufl_pkg::OP_GX: begin
            op <= ufl_pkg::OP_GY;
            pv_x <= ufl_pkg::sat32(r16[55:0]);
          end
          ufl_pkg::OP_GY: pv_y <= ufl_pkg::sat32(r16[55:0]);
          ufl_pkg::OP_V1: op <= ufl_pkg::OP_V2;
          ufl_pkg::OP_V2: op <= ufl_pkg::OP_W1;
          ufl_pkg::OP_W1: op <= ufl_pkg::OP_W2;
          ufl_pkg::OP_W2: op <= ufl_pkg::OP_WR;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      kind <= s_tuser[0];
      pos_x <= s_tdata[31:0];
      pos_y <= s_tdata[63:32];
      heading <= s_tdata[79:64];
      ref_x <= s_tdata[111:80];
      ref_y <= s_tdata[143:112];
      ref_heading <= s_tdata[159:144];
    end
    if (state == ufl_pkg::S_CLOAD) begin
      cx <= ufl_pkg::CORDIC_INIT;
      cy <= '0;
      it <= '0;
      flip <= (ang > 16'sd16384) || (ang < -16'sd16384);
      if (ang > 16'sd16384) cz <= z0 - 34'sh080000000;
      else if (ang < -16'sd16384) cz <= z0 + 34'sh080000000;
      else cz <= z0;
    end
    if (state == ufl_pkg::S_CORD && !cord_done) begin
      if (!cz[AW-1]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - at;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + at;
      end
      it <= it + 1'b1;
    end
    if (cord_done) begin
      cs_c <= flip ? -cx : cx;
      cs_s <= flip ? -cy : cy;
    end
    if (state == ufl_pkg::S_MLOAD) begin
      ma <= opa;
      mb <= opb;
      hi <= '0;
      lo <= '0;
      mcnt <= '0;
    end
    if (state == ufl_pkg::S_MUL && !mul_done) begin
      hi <= hi_sum >>> 1;
      lo <= {hi_sum[0], lo[MW-1:1]};
      mb <= mb >> 1;
      mcnt <= mcnt + 1'b1;
    end
    if (mul_done) begin
      case (op)
        ufl_pkg::OP_OX: ox <= pt_new;
        ufl_pkg::OP_OY: oy <= pt_new;
        ufl_pkg::OP_RX: rx <= pt_new;
        ufl_pkg::OP_RY: ry <= pt_new;
        ufl_pkg::OP_V1, ufl_pkg::OP_W1: tacc <= prod;
        ufl_pkg::OP_V2: lin <= ufl_pkg::sat32(rv[55:0]);
        ufl_pkg::OP_W2: wn <= ufl_pkg::sat32(rw[55:0]);
        ufl_pkg::OP_WR: trate <= ufl_pkg::sat32(r16[55:0]);
        default: ;
      endcase
    end
    if (out_load) begin
      m_tdata <= {ufl_pkg::sat32(56'(oy)), ufl_pkg::sat32(56'(ox)), trate, lin};
    end
  end

  a_mcnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ufl_pkg::S_MUL) |-> (mcnt <= MCW'(MW)))
    else $error("multiplier count out of range");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ufl_pkg::S_CLOAD))
    else $error("accepted transaction did not start the CORDIC");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("result was not presented");

  a_last_product: assert property (@(posedge clk) disable iff (rst)
    (mul_done && op == ufl_pkg::OP_WR) |=> (state == ufl_pkg::S_OUT))
    else $error("command did not reach the output state");

endmodule

// File: dv/unicycle_feedback_linearization_tb.sv
`timescale 1ns / 1ps

module unicycle_feedback_linearization_tb;

  localparam int STEPS = (ufl_pkg::DEF_CORDIC_STEPS > 24) ? 24 : ufl_pkg::DEF_CORDIC_STEPS;
  localparam int SETTLE = 800;
  localparam bit KIND_TICK = 1'b0;
  localparam bit KIND_CMD = 1'b1;

  typedef struct {
    bit kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [15:0] ref_heading;
  } pose_item_t;

  typedef struct {
    logic [31:0] linear_speed;
    logic [31:0] turn_rate;
    logic [31:0] point_x;
    logic [31:0] point_y;
  } drive_cmd_t;

  typedef struct {
    pose_item_t it;
    bit typed;
    drive_cmd_t want;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [159:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [127:0] m_tdata;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  unicycle_feedback_linearization uut (.*);

  always #5 clk = ~clk;

  longint eps_q, recip_q, gain_q, tvx_q, tvy_q;
  bit tmode_q;
  longint pvel_x, pvel_y;
  drive_cmd_t pending_cmds[$];
  int errors = 0;
  int tx_idle = 0;
  int rx_stall = 0;

  const longint atan_lut[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void turn_sincos(input logic signed [15:0] ang, output longint c,
                                      output longint s);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) * 65536;
    x = 652032874;
    y = 0;
    flip = 0;
    if (ang > 16384) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (ang < -16384) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_lut[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_lut[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void track_item(input pose_item_t it, input bit typed,
                                     input drive_cmd_t want);
    longint c, s, ox, oy, rc, rs, rx, ry, v, wn, w;
    drive_cmd_t r;
    turn_sincos(it.heading, c, s);
    ox = longint'(it.pos_x) + rnd_shift(eps_q * c, 30);
    oy = longint'(it.pos_y) + rnd_shift(eps_q * s, 30);
    if (it.kind == KIND_TICK) begin
      if (tmode_q) begin
        pvel_x = tvx_q;
        pvel_y = tvy_q;
      end else begin
        turn_sincos(it.ref_heading, rc, rs);
        rx = longint'(it.ref_x) + rnd_shift(eps_q * rc, 30);
        ry = longint'(it.ref_y) + rnd_shift(eps_q * rs, 30);
        pvel_x = clip32(rnd_shift(gain_q * (rx - ox), 16));
        pvel_y = clip32(rnd_shift(gain_q * (ry - oy), 16));
      end
    end else begin
      v = rnd_shift(pvel_x * c + pvel_y * s, 30);
      wn = clip32(rnd_shift(pvel_y * c - pvel_x * s, 30));
      w = rnd_shift(wn * recip_q, 16);
      r.linear_speed = 32'(clip32(v));
      r.turn_rate = 32'(clip32(w));
      r.point_x = 32'(clip32(ox));
      r.point_y = 32'(clip32(oy));
      pending_cmds.insert(pending_cmds.size(), typed ? want : r);
    end
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      ufl_pkg::REG_OFFSET_DISTANCE: eps_q = val & 32'h1FFFFF;
      ufl_pkg::REG_OFFSET_RECIPROCAL: recip_q = val & 32'h7FFFFFF;
      ufl_pkg::REG_POSITION_GAIN: gain_q = val & 32'h1FFFFFF;
      ufl_pkg::REG_TEST_MODE: tmode_q = val[0];
      ufl_pkg::REG_TEST_VEL_X: tvx_q = longint'($signed(val));
      ufl_pkg::REG_TEST_VEL_Y: tvy_q = longint'($signed(val));
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_item(input pose_item_t it, input bit typed, input drive_cmd_t want);
    while ($urandom_range(0, 99) < tx_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= it.kind;
    s_tdata <= {it.ref_heading, it.ref_y, it.ref_x, it.heading, it.pos_y, it.pos_x};
    do @(posedge clk); while (!s_tready);
    track_item(it, typed, want);
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
    endcase
  endfunction

  function automatic logic signed [15:0] rnd_turn();
    logic signed [15:0] odd[7] = '{16'sd16384, -16'sd16384, 16'sd16385, -16'sd16385,
                                   16'sh7fff, 16'sh8000, 16'sd0};
    if ($urandom_range(0, 7) == 0) return odd[$urandom_range(0, 6)];
    return 16'($urandom);
  endfunction

  function automatic pose_item_t rnd_item();
    pose_item_t it;
    it.kind = 1'($urandom_range(0, 1));
    it.pos_x = rnd_coord();
    it.pos_y = rnd_coord();
    it.heading = rnd_turn();
    it.ref_x = rnd_coord();
    it.ref_y = rnd_coord();
    it.ref_heading = rnd_turn();
    return it;
  endfunction

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_stall);
  end

  always @(posedge clk) begin
    drive_cmd_t got, exp_cmd;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96]};
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, m_tdata);
        errors++;
      end else begin
        exp_cmd = pending_cmds.pop_front();
        if (got.linear_speed !== exp_cmd.linear_speed) begin
          $display("%0t: linear_speed exp %h got %h", $time, exp_cmd.linear_speed,
                   got.linear_speed);
          errors++;
        end
        if (got.turn_rate !== exp_cmd.turn_rate) begin
          $display("%0t: turn_rate exp %h got %h", $time, exp_cmd.turn_rate, got.turn_rate);
          errors++;
        end
        if (got.point_x !== exp_cmd.point_x) begin
          $display("%0t: point_x exp %h got %h", $time, exp_cmd.point_x, got.point_x);
          errors++;
        end
        if (got.point_y !== exp_cmd.point_y) begin
          $display("%0t: point_y exp %h got %h", $time, exp_cmd.point_y, got.point_y);
          errors++;
        end
      end
    end
  end

  initial begin
    #60ms;
    $display("unicycle_feedback_linearization_tb NOT OK");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    drive_cmd_t none;
    pose_item_t it;
    int idle_modes[4][2] = '{'{0, 0}, '{84, 0}, '{0, 84}, '{30, 30}};
    logic [31:0] eps_pick[5] = '{32'd1, 32'd1048576, 32'd0, 32'hffffffff, 32'd6554};
    logic [31:0] rcp_pick[5] = '{32'd1, 32'd67108864, 32'd0, 32'hffffffff, 32'd655360};
    logic [31:0] gain_pick[4] = '{32'd0, 32'd16777216, 32'hffffffff, 32'd65536};
    none = '{0, 0, 0, 0};
    eps_q = 6554;
    recip_q = 655360;
    gain_q = 65536;
    tmode_q = 0;
    tvx_q = 0;
    tvy_q = 0;
    pvel_x = 0;
    pvel_y = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // With a zero offset the point is the position and, before any tick, speeds are zero.
    apb_write(ufl_pkg::REG_OFFSET_DISTANCE, 0);
    rows.insert(rows.size(), '{'{KIND_CMD, 32'sh7fffffff, 32'sh80000000, 16'sd0, 0, 0, 0}, 1,
                               '{32'h0, 32'h0, 32'h7fffffff, 32'h80000000}});
    rows.insert(rows.size(), '{'{KIND_CMD, 32'sh80000000, 32'sh7fffffff, 16'sh8000, 0, 0, 0}, 1,
                               '{32'h0, 32'h0, 32'h80000000, 32'h7fffffff}});
    rows.insert(rows.size(), '{'{KIND_TICK, 0, 0, 16'sd0, 32'sh7fffffff, 32'sh80000000, 16'sd0},
                               0, none});
    rows.insert(rows.size(), '{'{KIND_CMD, 5, -7, 16'sd0, 0, 0, 0}, 0, none});
    foreach (eps_pick[k]) begin
      rows.insert(rows.size(), '{'{KIND_CMD, 0, 0, $signed(16'(k * 16384 + 1)), 0, 0, 0}, 0,
                                 none});
    end
    rows.insert(rows.size(), '{'{KIND_TICK, 32'sh80000000, 32'sh7fffffff, 16'sh7fff,
                                 32'sh7fffffff, 32'sh80000000, 16'sh8000}, 0, none});
    rows.insert(rows.size(), '{'{KIND_CMD, 0, 0, 16'sd16384, 0, 0, 0}, 0, none});
    rows.insert(rows.size(), '{'{KIND_CMD, 0, 0, -16'sd16384, 0, 0, 0}, 0, none});
    rows.insert(rows.size(), '{'{KIND_CMD, 0, 0, 16'sd16385, 0, 0, 0}, 0, none});
    rows.insert(rows.size(), '{'{KIND_CMD, 0, 0, -16'sd16385, 0, 0, 0}, 0, none});
    rows.insert(rows.size(), '{'{KIND_TICK, 32'sd65536, -32'sd65536, 16'sd100,
                                 -32'sd131072, 32'sd196608, -16'sd3000}, 0, none});
    rows.insert(rows.size(), '{'{KIND_CMD, 32'sd65536, -32'sd65536, 16'sd8192, 0, 0, 0}, 0,
                               none});
    rows.insert(rows.size(), '{'{KIND_CMD, 32'sh7fffffff, 32'sh7fffffff, 16'sh7fff,
                                 32'hffffffff, 32'hffffffff, 16'hffff}, 0, none});
    foreach (rows[k]) send_item(rows[k].it, rows[k].typed, rows[k].want);

    drain();
    apb_write(ufl_pkg::REG_OFFSET_DISTANCE, 32'd1048576);
    foreach (rows[k]) if (k >= 2) send_item(rows[k].it, 0, none);

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      tx_idle = idle_modes[ph % 4][0];
      rx_stall = idle_modes[ph % 4][1];
      apb_write(ufl_pkg::REG_OFFSET_DISTANCE,
                (ph < 5) ? eps_pick[ph] : $urandom_range(0, 1 << 20));
      apb_write(ufl_pkg::REG_OFFSET_RECIPROCAL,
                (ph < 5) ? rcp_pick[ph] : $urandom_range(0, 1 << 26));
      apb_write(ufl_pkg::REG_POSITION_GAIN,
                (ph < 4) ? gain_pick[ph] : $urandom_range(0, 1 << 18));
      apb_write(ufl_pkg::REG_TEST_MODE,
                (ph % 3 == 1) ? 32'hffffffff : $urandom_range(0, 1) & ph[2]);
      apb_write(ufl_pkg::REG_TEST_VEL_X, (ph == 1) ? 32'h80000000 : $urandom);
      apb_write(ufl_pkg::REG_TEST_VEL_Y, (ph == 1) ? 32'h7fffffff : $urandom);
      apb_write(3'd6 + ph[0], $urandom);
      for (int n = 0; n < 105; n++) begin
        if (n == 50) begin
          s_tvalid <= 0;
          do @(posedge clk); while (pending_cmds.size() != 0);
        end
        it = rnd_item();
        send_item(it, 0, none);
      end
    end

    drain();
    if (errors == 0) begin
      $display("unicycle_feedback_linearization_tb OK");
    end else begin
      $display("unicycle_feedback_linearization_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/ufl_pkg.sv
sv/unicycle_feedback_linearization.sv
dv/unicycle_feedback_linearization_tb.sv
